[hw/rtl/frm_pkg.sv]
// Shared types and constants for the frame rate meter.
// Holds field widths, the rate scale constant and the control state type.
// No dependencies.
package frm_pkg;

    localparam int TIME_W    = 32;
    localparam int COUNT_W   = 32;
    localparam int RATE_W    = 16;
    localparam int SCALE_W   = 17;
    localparam logic [SCALE_W-1:0] RATE_SCALE = SCALE_W'(100000);
    localparam int PROD_W    = COUNT_W + SCALE_W;
    localparam int MUL_CNT_W = $clog2(SCALE_W);
    localparam int DIV_CNT_W = $clog2(PROD_W);
    localparam int IN_DATA_W = TIME_W + COUNT_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_DIV,
        S_OUT
    } t_state;

endpackage

[hw/rtl/frm_mul.sv]
// Shift-and-add multiplier of the event count delta by the rate scale.
// One bit of the scale constant is consumed per cycle.
// Depends on frm_pkg.
module frm_mul (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [frm_pkg::COUNT_W-1:0]       i_dc,
    output logic                              o_done,
    output logic [frm_pkg::PROD_W-1:0]        o_prod
);

    logic                             r_busy;
    logic                             r_done;
    logic [frm_pkg::MUL_CNT_W-1:0]    r_cnt;
    logic [frm_pkg::COUNT_W-1:0]      r_dc;
    logic [frm_pkg::SCALE_W-1:0]      r_k;
    logic [frm_pkg::PROD_W-1:0]       r_acc;
    logic [frm_pkg::COUNT_W:0]        w_sum;
    logic [frm_pkg::PROD_W-1:0]       n_acc;
    logic                             w_last;

    assign w_sum  = {1'b0, r_acc[frm_pkg::PROD_W-1:frm_pkg::SCALE_W]}
                  + {1'b0, (r_k[0] ? r_dc : '0)};
    assign n_acc  = {w_sum, r_acc[frm_pkg::SCALE_W-1:1]};
    assign w_last = (r_cnt == frm_pkg::MUL_CNT_W'(frm_pkg::SCALE_W - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (w_last) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dc  <= i_dc;
            r_k   <= frm_pkg::RATE_SCALE;
            r_acc <= '0;
        end else if (r_busy) begin
            r_k   <= {1'b0, r_k[frm_pkg::SCALE_W-1:1]};
            r_acc <= n_acc;
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

[hw/rtl/frm_div.sv]
// Restoring divider producing one quotient bit per cycle.
// Only the low bits of the quotient that form the rate are kept.
// Depends on frm_pkg.
module frm_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [frm_pkg::PROD_W-1:0]        i_dividend,
    input  logic [frm_pkg::TIME_W-1:0]        i_divisor,
    output logic                              o_done,
    output logic [frm_pkg::RATE_W-1:0]        o_quot
);

    logic                             r_busy;
    logic                             r_done;
    logic [frm_pkg::DIV_CNT_W-1:0]    r_cnt;
    logic [frm_pkg::PROD_W-1:0]       r_dvd;
    logic [frm_pkg::TIME_W-1:0]       r_dvs;
    logic [frm_pkg::TIME_W-1:0]       r_rem;
    logic [frm_pkg::RATE_W-1:0]       r_q;
    logic [frm_pkg::TIME_W:0]         w_trial;
    logic [frm_pkg::TIME_W:0]         w_diff;
    logic                             w_ge;
    logic                             w_last;

    assign w_trial = {r_rem, r_dvd[frm_pkg::PROD_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_dvs});
    assign w_diff  = w_trial - {1'b0, r_dvs};
    assign w_last  = (r_cnt == frm_pkg::DIV_CNT_W'(frm_pkg::PROD_W - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (w_last) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_dvs <= i_divisor;
            r_rem <= '0;
            r_q   <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[frm_pkg::PROD_W-2:0], 1'b0};
            r_rem <= w_ge ? w_diff[frm_pkg::TIME_W-1:0] : w_trial[frm_pkg::TIME_W-1:0];
            r_q   <= {r_q[frm_pkg::RATE_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

[hw/rtl/frame_rate_meter_top.sv]
// Top level of the frame rate meter: sample handling, control and output register.
// A measured rate passes through 17 multiplier and 49 divider steps and then the output
// register; the next sample is accepted only once that result is loaded into it.
// A zero rate skips the arithmetic and goes straight to the output register.
// Synchronous active-low reset clears the control state, the previous-sample flag and the output valid flag.
// Depends on frm_pkg, frm_mul and frm_div.
module frame_rate_meter_top (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [frm_pkg::IN_DATA_W-1:0]        s_axis_tdata,  // time_ms, event_count
    input  logic                                 s_axis_tuser,  // source_ready
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [frm_pkg::RATE_W-1:0]           m_axis_tdata   // rate_x100
);

    frm_pkg::t_state                   r_state;
    frm_pkg::t_state                   n_state;
    logic                              r_have_last;
    logic [frm_pkg::TIME_W-1:0]        r_last_time;
    logic [frm_pkg::COUNT_W-1:0]       r_last_count;
    logic [frm_pkg::TIME_W-1:0]        r_dt;
    logic [frm_pkg::RATE_W-1:0]        r_res;
    logic                              r_m_valid;
    logic [frm_pkg::RATE_W-1:0]        r_m_data;

    logic [frm_pkg::TIME_W-1:0]        w_now;
    logic [frm_pkg::COUNT_W-1:0]       w_cnt;
    logic [frm_pkg::TIME_W-1:0]        w_dt;
    logic [frm_pkg::COUNT_W-1:0]       w_dc;
    logic                              w_accept;
    logic                              w_go;
    logic                              w_in_ready;
    logic                              w_out_load;
    logic                              w_mul_done;
    logic [frm_pkg::PROD_W-1:0]        w_prod;
    logic                              w_div_start;
    logic                              w_div_done;
    logic [frm_pkg::RATE_W-1:0]        w_quot;

    assign w_now    = s_axis_tdata[frm_pkg::TIME_W-1:0];
    assign w_cnt    = s_axis_tdata[frm_pkg::IN_DATA_W-1:frm_pkg::TIME_W];
    assign w_dt     = w_now - r_last_time;
    assign w_dc     = w_cnt - r_last_count;
    assign w_accept = s_axis_tvalid && w_in_ready;
    assign w_go     = s_axis_tuser && r_have_last && (w_dt != '0);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            frm_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_state = w_go ? frm_pkg::S_MUL : frm_pkg::S_OUT;
                end
            end
            frm_pkg::S_MUL: begin
                if (w_mul_done) begin
                    n_state = frm_pkg::S_DIV;
                end
            end
            frm_pkg::S_DIV: begin
                if (w_div_done) begin
                    n_state = frm_pkg::S_OUT;
                end
            end
            frm_pkg::S_OUT: begin
                if (!r_m_valid || m_axis_tready) begin
                    n_state = frm_pkg::S_IDLE;
                end
            end
            default: n_state = frm_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        w_in_ready  = 1'b0;
        w_div_start = 1'b0;
        w_out_load  = 1'b0;
        unique case (r_state)
            frm_pkg::S_IDLE: w_in_ready  = 1'b1;
            frm_pkg::S_MUL:  w_div_start = w_mul_done;
            frm_pkg::S_DIV:  w_div_start = 1'b0;
            frm_pkg::S_OUT:  w_out_load  = !r_m_valid || m_axis_tready;
            default:         w_in_ready  = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= frm_pkg::S_IDLE;
            r_have_last <= 1'b0;
            r_m_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                r_have_last <= s_axis_tuser;
            end
            if (w_out_load) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && s_axis_tuser) begin
            r_last_time  <= w_now;
            r_last_count <= w_cnt;
        end
        if (w_accept) begin
            r_dt  <= w_dt;
            r_res <= '0;
        end else if (w_div_done) begin
            r_res <= w_quot;
        end
        if (w_out_load) begin
            r_m_data <= r_res;
        end
    end

    frm_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_accept && w_go),
        .i_dc    (w_dc),
        .o_done  (w_mul_done),
        .o_prod  (w_prod)
    );

    frm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_prod),
        .i_divisor  (r_dt),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    assign s_axis_tready = w_in_ready;
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

endmodule

[hw/rtl/frm_checker.sv]
// Port-level checker for the frame rate meter, attached to the top level by bind.
// Depends on frm_pkg and frame_rate_meter_top.
module frm_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    input  logic                            i_s_tready,
    input  logic                            i_s_tuser,
    input  logic                            i_m_tvalid,
    input  logic                            i_m_tready,
    input  logic [frm_pkg::RATE_W-1:0]      i_m_tdata
);

    // A stalled result keeps its valid flag.
    a_out_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tready |=> i_m_tvalid)
        else $error("result transaction dropped while stalled");

    // A stalled result keeps its data.
    a_out_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tready |=> $stable(i_m_tdata))
        else $error("result data changed while stalled");

    // Only one sample is in progress at a time.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && i_s_tready |=> !i_s_tready)
        else $error("second sample accepted while one is in progress");

    // A sample from an inactive source, accepted while no result is pending, is answered with a zero rate.
    a_not_ready_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && i_s_tready && !i_s_tuser && !i_m_tvalid
        |=> ##1 (i_m_tvalid && (i_m_tdata == '0)))
        else $error("inactive source did not give a zero rate");

endmodule

bind frame_rate_meter_top frm_checker u_frm_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (s_axis_tvalid),
    .i_s_tready (s_axis_tready),
    .i_s_tuser  (s_axis_tuser),
    .i_m_tvalid (m_axis_tvalid),
    .i_m_tready (m_axis_tready),
    .i_m_tdata  (m_axis_tdata)
);

[verif/tb_frame_rate_meter_top.sv]
// Self-checking testbench for frame_rate_meter_top: drives timestamp and event-count samples,
// predicts each rate in hundredths per second and compares every result transaction.
// Depends on frm_pkg and the frame_rate_meter_top RTL.
`timescale 1ns / 100ps

module tb_frame_rate_meter_top;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            s_axis_tvalid;
    logic                            s_axis_tready;
    logic [frm_pkg::IN_DATA_W-1:0]   s_axis_tdata;
    logic                            s_axis_tuser;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready;
    logic [frm_pkg::RATE_W-1:0]      m_axis_tdata;

    logic [frm_pkg::TIME_W-1:0]      prev_time;
    logic [frm_pkg::COUNT_W-1:0]     prev_count;
    logic                            prev_valid;
    logic [frm_pkg::RATE_W-1:0]      pending_rates[$];

    int gap_pct;
    int stall_pct;
    int hold_left;
    int err_count;

    frame_rate_meter_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("FAIL frame_rate_meter_top");
        $finish;
    end

    function automatic logic [frm_pkg::RATE_W-1:0] predict_rate(
        input logic [frm_pkg::TIME_W-1:0]  t_ms,
        input logic [frm_pkg::COUNT_W-1:0] cnt,
        input logic                        rdy
    );
        logic [frm_pkg::TIME_W-1:0]  dt;
        logic [frm_pkg::COUNT_W-1:0] dc;
        logic [63:0]                 quot;
        quot = '0;
        if (!rdy) begin
            prev_valid = 1'b0;
        end else if (!prev_valid) begin
            prev_time  = t_ms;
            prev_count = cnt;
            prev_valid = 1'b1;
        end else begin
            dt = t_ms - prev_time;
            dc = cnt - prev_count;
            prev_time  = t_ms;
            prev_count = cnt;
            if (dt != '0) begin
                quot = (64'(dc) * 64'(frm_pkg::RATE_SCALE)) / 64'(dt);
            end
        end
        return quot[frm_pkg::RATE_W-1:0];
    endfunction

    task automatic note_failure(input string what);
        if (err_count < 10) begin
            $display("%0t: %s", $time, what);
        end
        err_count++;
    endtask

    task automatic send_sample(
        input logic [frm_pkg::TIME_W-1:0]  t_ms,
        input logic [frm_pkg::COUNT_W-1:0] cnt,
        input logic                        rdy
    );
        while ($urandom_range(0, 99) < gap_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {cnt, t_ms};
        s_axis_tuser  <= rdy;
        @(posedge i_clk);
        while (!s_axis_tready) begin
            @(posedge i_clk);
        end
        pending_rates.push_back(predict_rate(t_ms, cnt, rdy));
    endtask

    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            m_axis_tready <= 1'b0;
            hold_left     <= hold_left - 1;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        logic [frm_pkg::RATE_W-1:0] want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_rates.size() == 0) begin
                note_failure($sformatf("unexpected rate transaction 0x%04h", m_axis_tdata));
            end else begin
                want = pending_rates.pop_front();
                if (m_axis_tdata !== want) begin
                    note_failure($sformatf("rate_x100 expected 0x%04h, got 0x%04h",
                                           want, m_axis_tdata));
                end
            end
        end
    end

    task automatic test_source_not_ready();
        send_sample(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        send_sample(32'h0000_0000, 32'h0000_0000, 1'b0);
    endtask

    task automatic test_first_and_steady();
        send_sample(32'd1000, 32'd50, 1'b1);
        send_sample(32'd2000, 32'd110, 1'b1);
        send_sample(32'd2017, 32'd111, 1'b1);
    endtask

    task automatic test_zero_elapsed();
        send_sample(32'd2017, 32'd200, 1'b1);
        send_sample(32'd3017, 32'd260, 1'b1);
    endtask

    task automatic test_counter_wrap();
        send_sample(32'd5, 32'd5, 1'b0);
        send_sample(32'hFFFF_FE00, 32'hFFFF_FFF0, 1'b1);
        send_sample(32'h0000_0200, 32'h0000_0010, 1'b1);
    endtask

    task automatic test_quotient_wrap();
        send_sample(32'h0000_0201, 32'h0000_000F, 1'b1);
        send_sample(32'h0000_0200, 32'h0000_000F, 1'b1);
        send_sample(32'h0000_01FF, 32'h0000_000E, 1'b1);
        send_sample(32'h0000_0000, 32'h0000_0000, 1'b0);
        send_sample(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        send_sample(32'h0000_0000, 32'h0000_0000, 1'b1);
    endtask

    // Mostly runs of ready samples with plausible steps, some with arbitrary jumps,
    // plus the odd not-ready sample that breaks a run.
    task automatic test_random_sessions(input int n_items, input int gap, input int stall);
        int                          sent;
        int                          run_len;
        logic [frm_pkg::TIME_W-1:0]  t_ms;
        logic [frm_pkg::COUNT_W-1:0] cnt;
        logic                        rdy;
        gap_pct   = gap;
        stall_pct = stall;
        sent      = 0;
        while (sent < n_items) begin
            t_ms    = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 5000)
                                                   : $urandom;
            cnt     = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 300)
                                                   : $urandom;
            run_len = $urandom_range(1, 24);
            for (int k = 0; k < run_len && sent < n_items; k++) begin
                rdy = ($urandom_range(0, 19) != 0);
                send_sample(t_ms, cnt, rdy);
                sent++;
                case ($urandom_range(0, 9))
                    0:       t_ms = t_ms;
                    1:       t_ms = t_ms + $urandom;
                    2, 3:    t_ms = t_ms + $urandom_range(1, 20);
                    default: t_ms = t_ms + $urandom_range(10, 2000);
                endcase
                case ($urandom_range(0, 9))
                    0:       cnt = cnt + $urandom;
                    1:       cnt = cnt;
                    default: cnt = cnt + $urandom_range(0, 150);
                endcase
            end
        end
    endtask

    task automatic test_output_backpressure();
        logic [frm_pkg::TIME_W-1:0]  t_ms;
        logic [frm_pkg::COUNT_W-1:0] cnt;
        gap_pct   = 0;
        stall_pct = 0;
        t_ms      = $urandom;
        cnt       = $urandom;
        hold_left = 600;
        for (int k = 0; k < 12; k++) begin
            send_sample(t_ms, cnt, 1'b1);
            t_ms = t_ms + $urandom_range(100, 1000);
            cnt  = cnt + $urandom_range(0, 100);
        end
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= 1'b0;
        m_axis_tready <= 1'b0;
        prev_time     = '0;
        prev_count    = '0;
        prev_valid    = 1'b0;
        gap_pct       = 0;
        stall_pct     = 0;
        hold_left     = 0;
        err_count     = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        gap_pct   = 29;
        stall_pct = 29;
        test_source_not_ready();
        test_first_and_steady();
        test_zero_elapsed();
        test_counter_wrap();
        test_quotient_wrap();

        test_random_sessions(160, 0, 0);
        test_output_backpressure();
        test_random_sessions(160, 81, 0);
        test_random_sessions(160, 0, 81);
        test_random_sessions(160, 29, 29);

        s_axis_tvalid <= 1'b0;
        while (pending_rates.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (150) @(posedge i_clk);

        if (err_count == 0 && pending_rates.size() == 0) begin
            $display("PASS frame_rate_meter_top");
        end else begin
            $display("FAIL frame_rate_meter_top");
        end
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/frm_pkg.sv
hw/rtl/frm_mul.sv
hw/rtl/frm_div.sv
hw/rtl/frame_rate_meter_top.sv
hw/rtl/frm_checker.sv
verif/tb_frame_rate_meter_top.sv
